>>> rtl/lndr_pkg.sv
// Shared constants and types for the longest non-decreasing run block.
package lndr_pkg;

  localparam int MaxElements = 512;
  localparam int ValW        = 32;
  localparam int AddrW       = $clog2(MaxElements);
  localparam int CntW        = $clog2(MaxElements + 1);
  localparam int LenW        = CntW;
  localparam int OutLenW     = 10;

  typedef struct packed {
    logic init;
    logic cmp_en;
  } scan_ctl_t;

endpackage

>>> rtl/lndr_store.sv
// Value and length store with one write port and one registered read port.
module lndr_store (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic        [lndr_pkg::AddrW-1:0]    wr_addr_i,
  input  logic signed [lndr_pkg::ValW-1:0]     wr_value_i,
  input  logic        [lndr_pkg::LenW-1:0]     wr_len_i,
  input  logic                                 rd_en_i,
  input  logic        [lndr_pkg::AddrW-1:0]    rd_addr_i,
  output logic signed [lndr_pkg::ValW-1:0]     rd_value_o,
  output logic        [lndr_pkg::LenW-1:0]     rd_len_o
);

  logic signed [lndr_pkg::ValW-1:0] value_mem [lndr_pkg::MaxElements];
  logic        [lndr_pkg::LenW-1:0] len_mem   [lndr_pkg::MaxElements];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      value_mem[wr_addr_i] <= wr_value_i;
      len_mem[wr_addr_i]   <= wr_len_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_value_o <= value_mem[rd_addr_i];
      rd_len_o   <= len_mem[rd_addr_i];
    end
  end

endmodule

>>> rtl/lndr_scan.sv
// Shared compare unit: folds one stored entry per cycle into the best length.
module lndr_scan (
  input  logic                                 clk_i,
  input  lndr_pkg::scan_ctl_t                  ctl_i,
  input  logic signed [lndr_pkg::ValW-1:0]     sample_i,
  input  logic signed [lndr_pkg::ValW-1:0]     rd_value_i,
  input  logic        [lndr_pkg::LenW-1:0]     rd_len_i,
  output logic        [lndr_pkg::LenW-1:0]     len_o
);

  logic [lndr_pkg::LenW-1:0] len_q;
  logic [lndr_pkg::LenW-1:0] len_d;
  logic [lndr_pkg::LenW-1:0] cand;
  logic                      take;

  assign cand = rd_len_i + lndr_pkg::LenW'(1);
  assign take = ctl_i.cmp_en && (rd_value_i <= sample_i) && (cand > len_q);

  always_comb begin
    len_d = len_q;
    if (ctl_i.init) begin
      len_d = lndr_pkg::LenW'(1);
    end else if (take) begin
      len_d = cand;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  assign len_o = len_q;

endmodule

>>> rtl/longest_nondecreasing_run_dp.sv
// Top level: sequencer, counters and result register of the run-length block.
//
//   channel | direction | handshake               | payload
//   in      | into      | in_valid_i / in_stall_o  | start_flag_i, sample_value_i
//   out     | out of    | out_valid_o / out_stall_i | length_ending_here_o,
//           |           |                          | longest_so_far_o, capacity_overflow_o
//
// An item scans the n stored elements before it, then passes drain and done; one
// memory read port feeds the single compare unit one entry per cycle.
// A full store or an empty sequence skips the scan.
// Reset clears the count, the running maximum and all handshake state; the
// stores need no clearing. A held result stalls only the final step of the
// next item; input is taken while a result waits.
module longest_nondecreasing_run_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   start_flag_i,
  input  logic signed [lndr_pkg::ValW-1:0]       sample_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [lndr_pkg::OutLenW-1:0]    length_ending_here_o,
  output logic        [lndr_pkg::OutLenW-1:0]    longest_so_far_o,
  output logic                                   capacity_overflow_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [lndr_pkg::CntW-1:0]         count_q, count_d;
  logic [lndr_pkg::LenW-1:0]         best_q, best_d;
  logic [lndr_pkg::AddrW-1:0]        idx_q, idx_d;
  logic                              rd_vld_q;
  logic                              ovf_q, ovf_d;
  logic signed [lndr_pkg::ValW-1:0]  sample_q, sample_d;
  logic                              out_valid_q, out_valid_d;
  logic [lndr_pkg::OutLenW-1:0]      out_len_q, out_len_d;
  logic [lndr_pkg::OutLenW-1:0]      out_best_q, out_best_d;
  logic                              out_ovf_q, out_ovf_d;

  logic                              in_xfer;
  logic                              out_xfer;
  logic                              load_ok;
  logic [lndr_pkg::CntW-1:0]         count_eff;
  logic [lndr_pkg::LenW-1:0]         best_eff;
  logic [lndr_pkg::LenW-1:0]         best_new;
  logic [lndr_pkg::LenW-1:0]         len_cur;
  logic signed [lndr_pkg::ValW-1:0]  rd_value;
  logic [lndr_pkg::LenW-1:0]         rd_len;
  logic                              wr_en;
  logic                              rd_en;
  logic [lndr_pkg::AddrW-1:0]        last_idx;
  lndr_pkg::scan_ctl_t               scan_ctl;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign load_ok    = !out_valid_q || !out_stall_i;

  assign count_eff = start_flag_i ? '0 : count_q;
  assign best_eff  = start_flag_i ? '0 : best_q;
  assign best_new  = (len_cur > best_q) ? len_cur : best_q;
  assign last_idx  = lndr_pkg::AddrW'(count_q - lndr_pkg::CntW'(1));

  assign rd_en   = (state_q == S_SCAN);
  assign wr_en   = (state_q == S_DONE) && load_ok && !ovf_q;

  assign scan_ctl.init   = in_xfer;
  assign scan_ctl.cmp_en = rd_vld_q;

  lndr_store u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (count_q[lndr_pkg::AddrW-1:0]),
    .wr_value_i (sample_q),
    .wr_len_i   (len_cur),
    .rd_en_i    (rd_en),
    .rd_addr_i  (idx_q),
    .rd_value_o (rd_value),
    .rd_len_o   (rd_len)
  );

  lndr_scan u_scan (
    .clk_i      (clk_i),
    .ctl_i      (scan_ctl),
    .sample_i   (sample_q),
    .rd_value_i (rd_value),
    .rd_len_i   (rd_len),
    .len_o      (len_cur)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    best_d      = best_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    sample_d    = sample_q;
    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    out_len_d   = out_len_q;
    out_best_d  = out_best_q;
    out_ovf_d   = out_ovf_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          sample_d = sample_value_i;
          count_d  = count_eff;
          best_d   = best_eff;
          idx_d    = '0;
          ovf_d    = (count_eff == lndr_pkg::CntW'(lndr_pkg::MaxElements));
          if (count_eff == '0 || ovf_d) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        idx_d = idx_q + lndr_pkg::AddrW'(1);
        if (idx_q == last_idx) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_ovf_d   = ovf_q;
          if (ovf_q) begin
            out_len_d  = '0;
            out_best_d = lndr_pkg::OutLenW'(best_q);
          end else begin
            out_len_d  = lndr_pkg::OutLenW'(len_cur);
            out_best_d = lndr_pkg::OutLenW'(best_new);
            best_d     = best_new;
            count_d    = count_q + lndr_pkg::CntW'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      best_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      best_q      <= best_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    ovf_q      <= ovf_d;
    sample_q   <= sample_d;
    out_len_q  <= out_len_d;
    out_best_q <= out_best_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o          = out_valid_q;
  assign length_ending_here_o = out_len_q;
  assign longest_so_far_o     = out_best_q;
  assign capacity_overflow_o  = out_ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lndr_pkg::CntW'(lndr_pkg::MaxElements))
    else $error("element count beyond capacity");

  a_read_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == S_SCAN)
    else $error("compare enabled without a scan read");

  a_ovf_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && capacity_overflow_o |-> length_ending_here_o == '0)
    else $error("dropped element reports a length");

  a_best_covers_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !capacity_overflow_o |-> longest_so_far_o >= length_ending_here_o)
    else $error("running maximum below current length");

endmodule
